/* design/ddc_pkg.sv */
package ddc_pkg;

	localparam int MAX_WIDTH  = 4096;
	localparam int MAX_HEIGHT = 4096;

	localparam int SAMPLE_W = 16;
	localparam int DIM_W    = 13;
	localparam int CFG_IDX_W = 2;

	localparam int COL_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int ROW_W = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;

	localparam int FIFO_DEPTH = 4;
	localparam int PTR_W      = $clog2(FIFO_DEPTH);
	localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

	localparam logic [CFG_IDX_W-1:0] REG_DIRECTION    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd2;

	localparam logic [DIM_W-1:0] RESET_WIDTH  = 13'd640;
	localparam logic [DIM_W-1:0] RESET_HEIGHT = 13'd480;

	localparam logic DIR_ENCODE = 1'b0;
	localparam logic DIR_DECODE = 1'b1;

	typedef enum logic [2:0] {
		KIND_ZERO  = 3'b001,
		KIND_LEFT  = 3'b010,
		KIND_ABOVE = 3'b100
	} kind_t;

	typedef struct packed {
		logic [DIM_W-1:0] width;
		logic [DIM_W-1:0] height;
	} geom_t;

	typedef struct packed {
		logic [SAMPLE_W-1:0] sample;
		logic [COL_W-1:0]    idx;
		kind_t               kind;
		logic                frame_end;
	} entry_t;

endpackage

/* design/ddc_front.sv */
module ddc_front (
	input  logic                           clk,
	input  logic                           arst_n,
	input  ddc_pkg::geom_t                 geom,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [ddc_pkg::SAMPLE_W-1:0]   in_sample,
	input  logic                           fifo_full,
	output logic                           push,
	output ddc_pkg::entry_t                push_entry
);

	logic [ddc_pkg::COL_W-1:0] col_q;
	logic [ddc_pkg::ROW_W-1:0] row_q;
	logic [ddc_pkg::COL_W:0]   w_eff;
	logic [ddc_pkg::ROW_W:0]   h_eff;
	logic                      last_col;
	logic                      last_row;

	// saturate geometry to the supported range
	always_comb begin
		if (geom.width == '0) begin
			w_eff = (ddc_pkg::COL_W + 1)'(1);
		end else if (32'(geom.width) > ddc_pkg::MAX_WIDTH) begin
			w_eff = (ddc_pkg::COL_W + 1)'(ddc_pkg::MAX_WIDTH);
		end else begin
			w_eff = (ddc_pkg::COL_W + 1)'(geom.width);
		end
		if (geom.height == '0) begin
			h_eff = (ddc_pkg::ROW_W + 1)'(1);
		end else if (32'(geom.height) > ddc_pkg::MAX_HEIGHT) begin
			h_eff = (ddc_pkg::ROW_W + 1)'(ddc_pkg::MAX_HEIGHT);
		end else begin
			h_eff = (ddc_pkg::ROW_W + 1)'(geom.height);
		end
	end

	assign last_col = ({1'b0, col_q} + 1'b1) >= w_eff;
	assign last_row = ({1'b0, row_q} + 1'b1) >= h_eff;

	assign in_ready = !fifo_full;
	assign push     = in_valid && !fifo_full;

	always_comb begin
		push_entry.sample    = in_sample;
		push_entry.idx       = col_q;
		push_entry.frame_end = last_col && last_row;
		if (row_q != '0) begin
			push_entry.kind = ddc_pkg::KIND_ABOVE;
		end else if (col_q != '0) begin
			push_entry.kind = ddc_pkg::KIND_LEFT;
		end else begin
			push_entry.kind = ddc_pkg::KIND_ZERO;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (push) begin
			if (last_col) begin
				col_q <= '0;
				row_q <= last_row ? '0 : row_q + 1'b1;
			end else begin
				col_q <= col_q + 1'b1;
			end
		end
	end

endmodule

/* design/ddc_fifo.sv */
module ddc_fifo (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  ddc_pkg::entry_t   push_entry,
	output logic              full,
	input  logic              pop,
	output logic              pop_valid,
	output ddc_pkg::entry_t   pop_entry
);

	ddc_pkg::entry_t             slots_q [ddc_pkg::FIFO_DEPTH];
	logic [ddc_pkg::PTR_W-1:0]   wr_ptr_q;
	logic [ddc_pkg::PTR_W-1:0]   rd_ptr_q;
	logic [ddc_pkg::CNT_W-1:0]   count_q;

	assign full      = count_q == ddc_pkg::CNT_W'(ddc_pkg::FIFO_DEPTH);
	assign pop_valid = count_q != '0;
	assign pop_entry = slots_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

/* design/ddc_back.sv */
module ddc_back (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           direction,
	input  logic                           pop_valid,
	input  ddc_pkg::entry_t                pop_entry,
	output logic                           pop,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [ddc_pkg::SAMPLE_W-1:0]   out_value,
	output logic                           out_last
);

	logic [ddc_pkg::SAMPLE_W-1:0] row_mem [ddc_pkg::MAX_WIDTH];

	logic                         valid_s1;
	ddc_pkg::entry_t              entry_s1;
	logic [ddc_pkg::SAMPLE_W-1:0] rdata_s1;
	logic                         hit_s1;
	logic [ddc_pkg::SAMPLE_W-1:0] left_q;

	logic                         out_valid_q;
	logic [ddc_pkg::SAMPLE_W-1:0] out_value_q;
	logic                         out_last_q;

	logic                         s1_fire;
	logic [ddc_pkg::SAMPLE_W-1:0] pred;
	logic [ddc_pkg::SAMPLE_W-1:0] pixel;
	logic [ddc_pkg::SAMPLE_W-1:0] result;

	assign s1_fire = valid_s1 && (!out_valid_q || out_ready);
	assign pop     = pop_valid && (!valid_s1 || s1_fire);

	always_comb begin
		unique case (entry_s1.kind)
			ddc_pkg::KIND_ABOVE: pred = hit_s1 ? left_q : rdata_s1;
			ddc_pkg::KIND_LEFT:  pred = left_q;
			default:             pred = '0;
		endcase
		if (direction == ddc_pkg::DIR_DECODE) begin
			pixel  = pred + entry_s1.sample;
			result = pixel;
		end else begin
			pixel  = entry_s1.sample;
			result = entry_s1.sample - pred;
		end
	end

	// line store, one write and one read port
	always_ff @(posedge clk) begin
		if (s1_fire) begin
			row_mem[entry_s1.idx] <= pixel;
		end
		if (pop) begin
			rdata_s1 <= row_mem[pop_entry.idx];
			entry_s1 <= pop_entry;
			// write in the same edge misses the read, take it from left_q
			hit_s1   <= s1_fire && (entry_s1.idx == pop_entry.idx);
		end
		if (s1_fire) begin
			out_value_q <= result;
			out_last_q  <= entry_s1.frame_end;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
			left_q      <= '0;
		end else begin
			if (pop) begin
				valid_s1 <= 1'b1;
			end else if (s1_fire) begin
				valid_s1 <= 1'b0;
			end
			if (s1_fire) begin
				out_valid_q <= 1'b1;
				left_q      <= pixel;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_value = out_value_q;
	assign out_last  = out_last_q;

endmodule

/* design/depth_delta_codec.sv */
// Left/top DPCM codec for a raster stream of 16-bit pixels, one beat per pixel in and out.
// Direction 0 encodes pixels to residuals (first pixel raw, rest of the top row minus the
// left neighbor, later rows minus the pixel above); direction 1 decodes with wrapping adds.
// Sustained rate is one pixel per clock while the output is not stalled, set by the single
// add or subtract per pixel and the one-write one-read line store of 4096 x 16 bits; each
// input beat passes the queue, the s1 stage register and the output register. Frame_width
// and frame_height saturate to 1..4096. Output tlast marks the last pixel of a frame. The
// line store needs no clearing after reset. Write configuration only while the block is idle.
module depth_delta_codec (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	input  logic [15:0]                     s_axis_tdata,   // sample
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	output logic [15:0]                     m_axis_tdata,   // value
	output logic                            m_axis_tlast,   // frame_end
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [ddc_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [ddc_pkg::DIM_W-1:0]       cfg_data
);

	logic              direction_q;
	ddc_pkg::geom_t    geom_q;

	logic              push;
	ddc_pkg::entry_t   push_entry;
	logic              fifo_full;
	logic              pop;
	logic              pop_valid;
	ddc_pkg::entry_t   pop_entry;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			direction_q   <= ddc_pkg::DIR_ENCODE;
			geom_q.width  <= ddc_pkg::RESET_WIDTH;
			geom_q.height <= ddc_pkg::RESET_HEIGHT;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				ddc_pkg::REG_DIRECTION:    direction_q   <= cfg_data[0];
				ddc_pkg::REG_FRAME_WIDTH:  geom_q.width  <= cfg_data;
				ddc_pkg::REG_FRAME_HEIGHT: geom_q.height <= cfg_data;
				default: ;
			endcase
		end
	end

	ddc_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.geom       (geom_q),
		.in_valid   (s_axis_tvalid),
		.in_ready   (s_axis_tready),
		.in_sample  (s_axis_tdata),
		.fifo_full  (fifo_full),
		.push       (push),
		.push_entry (push_entry)
	);

	ddc_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.full       (fifo_full),
		.pop        (pop),
		.pop_valid  (pop_valid),
		.pop_entry  (pop_entry)
	);

	ddc_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.direction  (direction_q),
		.pop_valid  (pop_valid),
		.pop_entry  (pop_entry),
		.pop        (pop),
		.out_valid  (m_axis_tvalid),
		.out_ready  (m_axis_tready),
		.out_value  (m_axis_tdata),
		.out_last   (m_axis_tlast)
	);

	a_push_not_full: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !fifo_full)
		else $error("push into full queue");

	a_pop_not_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> pop_valid)
		else $error("pop from empty queue");

	a_frame_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(push && push_entry.frame_end) |=> (push_entry.kind == ddc_pkg::KIND_ZERO))
		else $error("frame does not restart after frame end");

	a_accept_needs_room: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready) |-> push)
		else $error("accepted beat not queued");

endmodule

/* bench/ddc_frame_checker.sv */
module ddc_frame_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_axis_tvalid,
	input  logic                          s_axis_tready,
	input  logic [15:0]                   s_axis_tdata,   // sample
	input  logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	input  logic [15:0]                   m_axis_tdata,   // value
	input  logic                          m_axis_tlast,   // frame_end
	input  logic                          cfg_valid,
	input  logic                          cfg_ready,
	input  logic [ddc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [ddc_pkg::DIM_W-1:0]     cfg_data,
	output int unsigned                   mismatches,
	output int unsigned                   pending,
	output logic                          at_frame_start,
	output int unsigned                   beats_seen,
	output int unsigned                   frames_seen
);
	import ddc_pkg::*;

	typedef struct packed {
		logic [SAMPLE_W-1:0] value;
		logic                frame_end;
	} pixel_out_t;

	logic                dir;
	logic [DIM_W-1:0]    width_reg;
	logic [DIM_W-1:0]    height_reg;
	logic [SAMPLE_W-1:0] prev_row [MAX_WIDTH];
	logic [SAMPLE_W-1:0] left_pix;
	logic [COL_W-1:0]    col;
	logic [ROW_W-1:0]    row;
	pixel_out_t          expected_q [$];
	int unsigned         n_bad;
	int unsigned         n_beats;
	int unsigned         n_frames;

	always @(posedge clk or negedge arst_n) begin
		int unsigned         w_eff;
		int unsigned         h_eff;
		logic [SAMPLE_W-1:0] pred;
		logic [SAMPLE_W-1:0] pix;
		logic                last_c;
		logic                last_r;
		pixel_out_t          want;
		pixel_out_t          got;
		if (!arst_n) begin
			dir = DIR_ENCODE;
			width_reg = RESET_WIDTH;
			height_reg = RESET_HEIGHT;
			left_pix = '0;
			col = '0;
			row = '0;
			expected_q.delete();
			n_bad = 0;
			n_beats = 0;
			n_frames = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_DIRECTION:    dir = cfg_data[0];
					REG_FRAME_WIDTH:  width_reg = cfg_data;
					REG_FRAME_HEIGHT: height_reg = cfg_data;
					default: ;
				endcase
			end
			if (m_axis_tvalid && m_axis_tready) begin
				got = '{m_axis_tdata, m_axis_tlast};
				n_beats++;
				if (m_axis_tlast)
					n_frames++;
				if (expected_q.size() == 0) begin
					n_bad++;
					if (n_bad <= 10)
						$display("unexpected output beat: value %h last %b", got.value,
							got.frame_end);
				end else begin
					want = expected_q.pop_front();
					if (got.value !== want.value || got.frame_end !== want.frame_end) begin
						n_bad++;
						if (n_bad <= 10)
							$display("output beat %0d: expected value %h last %b, got value %h last %b",
								n_beats, want.value, want.frame_end, got.value, got.frame_end);
					end
				end
			end
			if (s_axis_tvalid && s_axis_tready) begin
				w_eff = (width_reg == 0) ? 1 : (width_reg > MAX_WIDTH) ? MAX_WIDTH : width_reg;
				h_eff = (height_reg == 0) ? 1 : (height_reg > MAX_HEIGHT) ? MAX_HEIGHT : height_reg;
				last_c = (col + 1 >= w_eff);
				last_r = (row + 1 >= h_eff);
				if (row == 0)
					pred = (col == 0) ? '0 : left_pix;
				else
					pred = prev_row[col];
				if (dir == DIR_ENCODE) begin
					pix = s_axis_tdata;
					want.value = s_axis_tdata - pred;
				end else begin
					pix = s_axis_tdata + pred;
					want.value = pix;
				end
				want.frame_end = last_c && last_r;
				expected_q.push_back(want);
				// line store and left neighbor always hold pixels, never residuals
				prev_row[col] = pix;
				left_pix = pix;
				if (last_c) begin
					col = '0;
					row = last_r ? '0 : row + 1'b1;
				end else begin
					col = col + 1'b1;
				end
			end
		end
		mismatches <= n_bad;
		pending <= expected_q.size();
		at_frame_start <= (col == 0) && (row == 0);
		beats_seen <= n_beats;
		frames_seen <= n_frames;
	end

endmodule

/* bench/tb.sv */
module tb;
	import ddc_pkg::*;

	localparam int unsigned           ITEMS     = 650;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE = CFG_IDX_W'(3);

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 s_axis_tvalid = 1'b0;
	logic                 s_axis_tready;
	logic [15:0]          s_axis_tdata = '0;   // sample
	logic                 m_axis_tvalid;
	logic                 m_axis_tready = 1'b0;
	logic [15:0]          m_axis_tdata;        // value
	logic                 m_axis_tlast;        // frame_end
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [DIM_W-1:0]     cfg_data = '0;

	int unsigned mismatches;
	int unsigned pending;
	int unsigned beats_seen;
	int unsigned frames_seen;
	logic        at_frame_start;

	int unsigned burst_left = 0;
	int unsigned sent = 0;
	int unsigned settings = 0;
	int unsigned cur_w = 1;
	bit          quiet = 1'b0;

	logic [5:0] ready_tick;
	logic [1:0] ready_mode;
	logic [7:0] ready_pat;

	depth_delta_codec u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	ddc_frame_checker u_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.s_axis_tvalid  (s_axis_tvalid),
		.s_axis_tready  (s_axis_tready),
		.s_axis_tdata   (s_axis_tdata),
		.m_axis_tvalid  (m_axis_tvalid),
		.m_axis_tready  (m_axis_tready),
		.m_axis_tdata   (m_axis_tdata),
		.m_axis_tlast   (m_axis_tlast),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.mismatches     (mismatches),
		.pending        (pending),
		.at_frame_start (at_frame_start),
		.beats_seen     (beats_seen),
		.frames_seen    (frames_seen)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// receiver stall pattern, reshuffled each time ready_tick wraps to zero
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
			ready_tick <= '0;
			ready_mode <= '0;
			ready_pat <= 8'b1101_0010;
		end else begin
			ready_tick <= ready_tick + 1'b1;
			if (ready_tick == 0)
				ready_mode <= $urandom_range(0, 3);
			ready_pat <= {ready_pat[6:0], ready_pat[7]};
			case (ready_mode)
				2'd0:    m_axis_tready <= 1'b1;
				2'd1:    m_axis_tready <= $urandom_range(0, 1);
				2'd2:    m_axis_tready <= ($urandom_range(0, 3) == 0);
				default: m_axis_tready <= ready_pat[7];
			endcase
		end
	end

	function automatic int unsigned eff_dim(input logic [DIM_W-1:0] v, input int unsigned lim);
		return (v == 0) ? 1 : (v > lim) ? lim : v;
	endfunction

	task automatic configure(input logic d, input logic [DIM_W-1:0] w,
		input logic [DIM_W-1:0] h, input bit spare);
		logic [CFG_IDX_W-1:0] idx [4];
		logic [DIM_W-1:0]     val [4];
		int unsigned          n;
		idx = '{REG_DIRECTION, REG_FRAME_WIDTH, REG_FRAME_HEIGHT, REG_SPARE};
		val = '{DIM_W'(d), w, h, DIM_W'($urandom)};
		n = spare ? 4 : 3;
		for (int i = 0; i < n; i++) begin
			cfg_valid <= 1'b1;
			cfg_index <= idx[i];
			cfg_data <= val[i];
			@(posedge clk);
			while (!cfg_ready)
				@(posedge clk);
		end
		cfg_valid <= 1'b0;
		cur_w = eff_dim(w, MAX_WIDTH);
		settings++;
	endtask

	task automatic send_sample(input logic [15:0] s);
		int unsigned gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 16);
			gap = quiet ? 0 : $urandom_range(0, 6);
			if (gap != 0) begin
				s_axis_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= s;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		burst_left--;
		sent++;
	endtask

	task automatic wait_drained();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
	endtask

	initial begin
		logic [15:0]      enc_frame [6];
		logic [15:0]      pixel;
		logic [15:0]      delta;
		logic             d;
		logic [DIM_W-1:0] w_raw;
		logic [DIM_W-1:0] h_raw;
		int unsigned      w_eff;
		int unsigned      h_eff;
		int unsigned      area;
		int unsigned      n;
		enc_frame = '{16'hFFFF, 16'h0000, 16'h8000, 16'h0001, 16'h7FFF, 16'hFFFE};
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// raw first pixel, left differences, above differences, wrap at both ends
		configure(DIR_ENCODE, 13'd3, 13'd2, 1'b0);
		foreach (enc_frame[i])
			send_sample(enc_frame[i]);
		wait_drained();
		// zero width and height act as one: every pixel is a whole frame
		configure(DIR_DECODE, '0, '0, 1'b0);
		send_sample(16'hFFFF);
		send_sample(16'h8000);
		wait_drained();
		// oversize geometry saturates, spare index must be ignored
		configure(DIR_ENCODE, '1, '1, 1'b1);
		for (int i = 0; i < 4; i++)
			send_sample(16'h0001 << (4 * i));
		wait_drained();
		// shrink mid-row and flip direction mid-frame
		configure(DIR_DECODE, 13'd2, 13'd2, 1'b0);
		send_sample(16'hFFFF);
		send_sample(16'h0001);
		send_sample(16'h8000);
		send_sample(16'h7FFF);
		wait_drained();
		// height shrink mid-frame ends the frame on this row
		configure(DIR_ENCODE, 13'd2, 13'd1, 1'b1);
		send_sample(16'h0000);
		send_sample(16'hFFFF);

		while (sent < ITEMS) begin
			wait_drained();
			d = $urandom_range(0, 1);
			case ($urandom_range(0, 15))
				0, 1, 2, 3, 4, 5, 6, 7: w_raw = $urandom_range(1, 6);
				8, 9, 10:               w_raw = $urandom_range(7, 40);
				11:                     w_raw = '0;
				12:                     w_raw = DIM_W'(MAX_WIDTH);
				13:                     w_raw = '1;
				14:                     w_raw = $urandom_range(MAX_WIDTH + 1, 8191);
				default:                w_raw = 13'd1;
			endcase
			case ($urandom_range(0, 15))
				0, 1, 2, 3, 4, 5, 6, 7, 8, 9: h_raw = $urandom_range(1, 5);
				10:                           h_raw = '0;
				11:                           h_raw = '1;
				12:                           h_raw = DIM_W'(MAX_HEIGHT);
				default:                      h_raw = $urandom_range(6, 12);
			endcase
			w_eff = eff_dim(w_raw, MAX_WIDTH);
			// growing the row mid-frame would read line store entries never written
			if (!at_frame_start && w_eff > cur_w) begin
				w_raw = $urandom_range(1, cur_w);
				w_eff = w_raw;
			end
			h_eff = eff_dim(h_raw, MAX_HEIGHT);
			configure(d, w_raw, h_raw, $urandom_range(0, 7) == 0);
			quiet = ($urandom_range(0, 3) == 0);
			area = w_eff * h_eff;
			if (area <= 48) begin
				n = area * $urandom_range(1, 3);
				if ($urandom_range(0, 3) == 0)
					n += $urandom_range(1, area);
			end else begin
				n = $urandom_range(3, 60);
			end
			pixel = $urandom;
			for (int i = 0; i < n; i++) begin
				case ($urandom_range(0, 9))
					0, 1: delta = $urandom;
					2: begin
						case ($urandom_range(0, 3))
							0:       delta = '0;
							1:       delta = '1;
							2:       delta = 16'h8000;
							default: delta = 16'h7FFF;
						endcase
					end
					default: delta = 16'($urandom_range(0, 32)) - 16'd16;
				endcase
				if (d == DIR_ENCODE) begin
					pixel = pixel + delta;
					send_sample(pixel);
				end else begin
					send_sample(delta);
				end
				if ($urandom_range(0, 99) == 0)
					wait_drained();
			end
		end

		wait_drained();
		repeat (20) @(posedge clk);
		$display("run covered %0d output beats, %0d frame ends, %0d register settings",
			beats_seen, frames_seen, settings);
		if (mismatches == 0)
			$display("depth_delta_codec regression: pass");
		else
			$display("depth_delta_codec regression: fail");
		$finish;
	end

	initial begin
		#3000000;
		$display("timeout with %0d beats outstanding", pending);
		$display("depth_delta_codec regression: fail");
		$finish;
	end

endmodule
